FILE: hdl/ffba_pkg.sv
// Package for the first-fit block allocator: heap geometry constants,
// the input and output word types and the layout of one block table entry.
// It depends on nothing else.
package ffba_pkg;

  localparam int HEAP_BYTES  = 4096;
  localparam int ALIGN_BYTES = 8;
  localparam int NUM_BLOCKS  = HEAP_BYTES / ALIGN_BYTES;
  localparam int BLK_W       = $clog2(NUM_BLOCKS);
  localparam int LEN_W       = BLK_W + 1;
  localparam int ALIGN_SH    = $clog2(ALIGN_BYTES);

  localparam int SIZE_W = 13;
  localparam int OFFS_W = 12;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef struct packed {
    op_t               operation;
    logic [SIZE_W-1:0] size_bytes;
    logic [OFFS_W-1:0] region_offset;
  } in_word_t;

  typedef struct packed {
    logic              success;
    logic [OFFS_W-1:0] granted_offset;
  } out_word_t;

  typedef struct packed {
    logic             mark;
    logic [LEN_W-1:0] len;
  } entry_t;

endpackage

FILE: hdl/first_fit_block_allocator.sv
// First-fit block allocator: one words-in, words-out channel pair around a
// block table held in a synchronous memory with a registered read port.
// Depends on ffba_pkg.
// A free goes straight to the done state and the output register; a valid
// allocation first runs a first-fit scan of the block table from entry 0.
// One word is in work at a time. The scan reads one table entry per cycle
// through the memory read port. After reset the table is cleared, one entry
// a cycle, through all NUM_BLOCKS (512) entries, during which in_stall
// stays high.
module first_fit_block_allocator
  import ffba_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_t;

  state_t state, state_next;

  entry_t mem [NUM_BLOCKS];
  entry_t rdata;

  logic             we;
  logic [BLK_W-1:0] waddr;
  entry_t           wdata;
  logic [BLK_W-1:0] raddr;

  logic [BLK_W-1:0] clr_addr, clr_addr_next;
  logic [BLK_W-1:0] pos, pos_next;
  logic [BLK_W-1:0] cand, cand_next;
  logic [LEN_W-1:0] need, need_next;
  out_word_t        res, res_next;

  logic             in_fire;
  logic             load_out;
  logic [SIZE_W:0]  size_round;
  logic [SIZE_W:0]  need_calc;
  logic [OFFS_W:0]  free_idx;
  logic [LEN_W-1:0] jump;
  logic [LEN_W-1:0] skip_to;
  logic [LEN_W-1:0] room;
  logic [LEN_W-1:0] span;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  assign in_stall = (state != ST_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign load_out = (state == ST_DONE) && (!out_valid || !out_stall);

  assign size_round = {1'b0, in_data.size_bytes} + (SIZE_W+1)'(ALIGN_BYTES - 1);
  assign need_calc  = size_round >> ALIGN_SH;
  assign free_idx   = {1'b0, in_data.region_offset} >> ALIGN_SH;

  assign jump    = (rdata.len == '0) ? LEN_W'(1) : rdata.len;
  assign skip_to = {1'b0, pos} + jump;
  assign room    = LEN_W'(NUM_BLOCKS) - {1'b0, cand};
  assign span    = {1'b0, pos} - {1'b0, cand} + LEN_W'(1);

  always_comb begin
    state_next    = state;
    clr_addr_next = clr_addr;
    pos_next      = pos;
    cand_next     = cand;
    need_next     = need;
    res_next      = res;
    we            = 1'b0;
    waddr         = '0;
    wdata         = '0;
    raddr         = '0;

    unique case (state)
      ST_CLEAR: begin
        we            = 1'b1;
        waddr         = clr_addr;
        clr_addr_next = clr_addr + BLK_W'(1);
        if (clr_addr == BLK_W'(NUM_BLOCKS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          res_next = '0;
          if (in_data.operation == OP_FREE) begin
            if (free_idx < (OFFS_W+1)'(NUM_BLOCKS)) begin
              we               = 1'b1;
              waddr            = free_idx[BLK_W-1:0];
              res_next.success = 1'b1;
            end
            state_next = ST_DONE;
          end else if (in_data.size_bytes == '0 ||
                       need_calc > (SIZE_W+1)'(NUM_BLOCKS)) begin
            state_next = ST_DONE;
          end else begin
            need_next  = need_calc[LEN_W-1:0];
            pos_next   = '0;
            cand_next  = '0;
            raddr      = '0;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (rdata.mark) begin
          if (skip_to >= LEN_W'(NUM_BLOCKS)) begin
            state_next = ST_DONE;
          end else begin
            cand_next = skip_to[BLK_W-1:0];
            pos_next  = skip_to[BLK_W-1:0];
            raddr     = skip_to[BLK_W-1:0];
          end
        end else if (pos == cand && need > room) begin
          state_next = ST_DONE;
        end else if (span == need) begin
          we                      = 1'b1;
          waddr                   = cand;
          wdata.mark              = 1'b1;
          wdata.len               = need;
          res_next.success        = 1'b1;
          res_next.granted_offset = {cand, {ALIGN_SH{1'b0}}};
          state_next              = ST_DONE;
        end else begin
          pos_next = pos + BLK_W'(1);
          raddr    = pos + BLK_W'(1);
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos  <= pos_next;
    cand <= cand_next;
    need <= need_next;
    res  <= res_next;
    if (load_out) begin
      out_data <= res;
    end
  end

endmodule

FILE: hdl/ffba_checker.sv
// Port-level checks for the first-fit block allocator, attached by bind.
// Depends on ffba_pkg and on the ports of first_fit_block_allocator.
module ffba_checker
  import ffba_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  a_clear_after_reset: assert property (@(posedge clk) rst |=> in_stall)
    else $error("input accepted during the table clear after reset");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("a second word was accepted while one is in work");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.success |-> out_data.granted_offset == '0)
    else $error("failed result carries a nonzero offset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
